FILE: rtl/sit_pkg.sv
// Shared definitions for the segment intersection test core.
// Holds register indexes, register widths and the bounding-box flag word.
// No dependencies; used by rtl/segment_intersection_test_core.sv.
package sit_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 63;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEN_TOL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_TOL = 1'b1;

    // Register widths.
    localparam int LEN_TOL_W  = 32;
    localparam int AREA_TOL_W = 63;

    // Field width of every coordinate port.
    localparam int FIELD_W = 32;

    // Results of the widened bounding-box checks for one word.
    typedef struct packed {
        logic reject;   // boxes are apart by more than the length tolerance
        logic c_in_ab;  // C lies inside the widened box of AB
        logic d_in_ab;  // D lies inside the widened box of AB
        logic a_in_cd;  // A lies inside the widened box of CD
        logic b_in_cd;  // B lies inside the widened box of CD
    } t_box_flags;

endpackage

FILE: rtl/sit_cross.sv
// Two-stage exact cross product u1*v1 - u2*v2 on signed coordinate differences.
// Stage one registers both products, stage two registers their difference.
// Depends on nothing outside this file; the width comes from parameter W.
module sit_cross #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic signed [W:0]     i_u1,
    input  logic signed [W:0]     i_v1,
    input  logic signed [W:0]     i_u2,
    input  logic signed [W:0]     i_v2,
    output logic signed [2*W+1:0] o_cross
);

    localparam int PW = 2 * W + 2;

    logic signed [PW-1:0] n_p1;
    logic signed [PW-1:0] n_p2;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic signed [PW-1:0] r_cross;

    // Operands are sign-extended to the product width so the product is exact.
    assign n_p1 = $signed({{(W+1){i_u1[W]}}, i_u1}) * $signed({{(W+1){i_v1[W]}}, i_v1});
    assign n_p2 = $signed({{(W+1){i_u2[W]}}, i_u2}) * $signed({{(W+1){i_v2[W]}}, i_v2});

    // Product stage.
    always_ff @(posedge i_clk) begin
        r_p1 <= n_p1;
        r_p2 <= n_p2;
    end

    // Difference stage; it cannot overflow at this width.
    always_ff @(posedge i_clk) begin
        r_cross <= r_p1 - r_p2;
    end

    assign o_cross = r_cross;

endmodule

FILE: rtl/segment_intersection_test_core.sv
// Segment intersection test core: o_done follows start through r_v1 to r_v4 and r_done.
// Throughput one word per cycle; busy is always low and nothing stalls.
// Stages: differences and box bounds, products and box checks, cross products,
// tolerance compares, final decision. The receiver cannot stall; results are
// strobed by o_done for one cycle. Synchronous active-low reset clears the
// valid pipeline and both tolerance registers.
module segment_intersection_test_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [sit_pkg::FIELD_W-1:0] i_a_x,
    input  logic signed [sit_pkg::FIELD_W-1:0] i_a_y,
    input  logic signed [sit_pkg::FIELD_W-1:0] i_b_x,
    input  logic signed [sit_pkg::FIELD_W-1:0] i_b_y,
    input  logic signed [sit_pkg::FIELD_W-1:0] i_c_x,
    input  logic signed [sit_pkg::FIELD_W-1:0] i_c_y,
    input  logic signed [sit_pkg::FIELD_W-1:0] i_d_x,
    input  logic signed [sit_pkg::FIELD_W-1:0] i_d_y,
    input  logic                              i_cfg_we,
    input  logic [sit_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sit_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                              o_done,
    output logic                              o_intersects
);

    localparam int W  = COORD_WIDTH;
    // Box sums: coordinate plus length tolerance, with a sign bit and a carry bit of headroom.
    localparam int SW = ((W > sit_pkg::LEN_TOL_W) ? W : sit_pkg::LEN_TOL_W) + 2;
    // Cross product width.
    localparam int OW = 2 * W + 2;
    // Tolerance compare width.
    localparam int TW = ((OW > sit_pkg::AREA_TOL_W + 1) ? OW : sit_pkg::AREA_TOL_W + 1) + 1;

    function automatic logic signed [SW-1:0] ext_c(input logic signed [W-1:0] v);
        return {{(SW-W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [W:0] dif(input logic signed [W-1:0] p,
                                              input logic signed [W-1:0] q);
        return {p[W-1], p} - {q[W-1], q};
    endfunction

    function automatic logic signed [W-1:0] mn(input logic signed [W-1:0] p,
                                               input logic signed [W-1:0] q);
        return (p < q) ? p : q;
    endfunction

    function automatic logic signed [W-1:0] mx(input logic signed [W-1:0] p,
                                               input logic signed [W-1:0] q);
        return (p > q) ? p : q;
    endfunction

    // Configuration registers.
    logic [sit_pkg::LEN_TOL_W-1:0]  r_len_tol;
    logic [sit_pkg::AREA_TOL_W-1:0] r_area_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_tol  <= '0;
            r_area_tol <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sit_pkg::REG_LEN_TOL:  r_len_tol  <= i_cfg_wdata[sit_pkg::LEN_TOL_W-1:0];
                sit_pkg::REG_AREA_TOL: r_area_tol <= i_cfg_wdata[sit_pkg::AREA_TOL_W-1:0];
            endcase
        end
    end

    // Every cycle takes a word, so the core never reports busy.
    assign busy = 1'b0;

    // Coordinates are the low COORD_WIDTH bits of each field.
    logic signed [W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    assign ax = i_a_x[W-1:0];
    assign ay = i_a_y[W-1:0];
    assign bx = i_b_x[W-1:0];
    assign by = i_b_y[W-1:0];
    assign cx = i_c_x[W-1:0];
    assign cy = i_c_y[W-1:0];
    assign dx = i_d_x[W-1:0];
    assign dy = i_d_y[W-1:0];

    // Valid pipeline.
    logic r_v1, r_v2, r_v3, r_v4, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= start && !busy;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_done <= r_v4;
        end
    end

    // Stage 1: coordinate differences, segment boxes and endpoints.
    logic signed [W:0]   r_bax, r_bay, r_cax, r_cay, r_dax, r_day;
    logic signed [W:0]   r_dcx, r_dcy, r_acx, r_acy, r_bcx, r_bcy;
    logic signed [W-1:0] r_ab_min_x, r_ab_max_x, r_ab_min_y, r_ab_max_y;
    logic signed [W-1:0] r_cd_min_x, r_cd_max_x, r_cd_min_y, r_cd_max_y;
    logic signed [W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        r_bax <= dif(bx, ax);
        r_bay <= dif(by, ay);
        r_cax <= dif(cx, ax);
        r_cay <= dif(cy, ay);
        r_dax <= dif(dx, ax);
        r_day <= dif(dy, ay);
        r_dcx <= dif(dx, cx);
        r_dcy <= dif(dy, cy);
        r_acx <= dif(ax, cx);
        r_acy <= dif(ay, cy);
        r_bcx <= dif(bx, cx);
        r_bcy <= dif(by, cy);
        r_ab_min_x <= mn(ax, bx);
        r_ab_max_x <= mx(ax, bx);
        r_ab_min_y <= mn(ay, by);
        r_ab_max_y <= mx(ay, by);
        r_cd_min_x <= mn(cx, dx);
        r_cd_max_x <= mx(cx, dx);
        r_cd_min_y <= mn(cy, dy);
        r_cd_max_y <= mx(cy, dy);
        r_ax <= ax;
        r_ay <= ay;
        r_bx <= bx;
        r_by <= by;
        r_cx <= cx;
        r_cy <= cy;
        r_dx <= dx;
        r_dy <= dy;
    end

    // Stage 2: boxes widened by the length tolerance, and the box checks.
    logic signed [SW-1:0] len_s;
    logic signed [SW-1:0] ab_lo_x, ab_hi_x, ab_lo_y, ab_hi_y;
    logic signed [SW-1:0] cd_lo_x, cd_hi_x, cd_lo_y, cd_hi_y;
    sit_pkg::t_box_flags  n_box;
    sit_pkg::t_box_flags  r_box2, r_box3, r_box4;

    assign len_s   = $signed({{(SW-sit_pkg::LEN_TOL_W){1'b0}}, r_len_tol});
    assign ab_lo_x = ext_c(r_ab_min_x) - len_s;
    assign ab_hi_x = ext_c(r_ab_max_x) + len_s;
    assign ab_lo_y = ext_c(r_ab_min_y) - len_s;
    assign ab_hi_y = ext_c(r_ab_max_y) + len_s;
    assign cd_lo_x = ext_c(r_cd_min_x) - len_s;
    assign cd_hi_x = ext_c(r_cd_max_x) + len_s;
    assign cd_lo_y = ext_c(r_cd_min_y) - len_s;
    assign cd_hi_y = ext_c(r_cd_max_y) + len_s;

    always_comb begin
        n_box.reject  = (ab_hi_x < ext_c(r_cd_min_x)) || (cd_hi_x < ext_c(r_ab_min_x)) ||
                        (ab_hi_y < ext_c(r_cd_min_y)) || (cd_hi_y < ext_c(r_ab_min_y));
        n_box.c_in_ab = (ext_c(r_cx) >= ab_lo_x) && (ext_c(r_cx) <= ab_hi_x) &&
                        (ext_c(r_cy) >= ab_lo_y) && (ext_c(r_cy) <= ab_hi_y);
        n_box.d_in_ab = (ext_c(r_dx) >= ab_lo_x) && (ext_c(r_dx) <= ab_hi_x) &&
                        (ext_c(r_dy) >= ab_lo_y) && (ext_c(r_dy) <= ab_hi_y);
        n_box.a_in_cd = (ext_c(r_ax) >= cd_lo_x) && (ext_c(r_ax) <= cd_hi_x) &&
                        (ext_c(r_ay) >= cd_lo_y) && (ext_c(r_ay) <= cd_hi_y);
        n_box.b_in_cd = (ext_c(r_bx) >= cd_lo_x) && (ext_c(r_bx) <= cd_hi_x) &&
                        (ext_c(r_by) >= cd_lo_y) && (ext_c(r_by) <= cd_hi_y);
    end

    // Box flags ride along with the cross products.
    always_ff @(posedge i_clk) begin
        r_box2 <= n_box;
        r_box3 <= r_box2;
        r_box4 <= r_box3;
    end

    // Stages 2 and 3: the four orientations.
    logic signed [OW-1:0] abc, abd, cda, cdb;

    sit_cross #(.W(W)) u_abc (
        .i_clk(i_clk), .i_u1(r_bax), .i_v1(r_cay), .i_u2(r_bay), .i_v2(r_cax), .o_cross(abc)
    );
    sit_cross #(.W(W)) u_abd (
        .i_clk(i_clk), .i_u1(r_bax), .i_v1(r_day), .i_u2(r_bay), .i_v2(r_dax), .o_cross(abd)
    );
    sit_cross #(.W(W)) u_cda (
        .i_clk(i_clk), .i_u1(r_dcx), .i_v1(r_acy), .i_u2(r_dcy), .i_v2(r_acx), .o_cross(cda)
    );
    sit_cross #(.W(W)) u_cdb (
        .i_clk(i_clk), .i_u1(r_dcx), .i_v1(r_bcy), .i_u2(r_dcy), .i_v2(r_bcx), .o_cross(cdb)
    );

    // Stage 4: compare each orientation against plus and minus the area tolerance.
    logic signed [TW-1:0] area_p, area_n;
    logic signed [TW-1:0] abc_t, abd_t, cda_t, cdb_t;
    logic r_abc_hi, r_abc_lo, r_abd_hi, r_abd_lo;
    logic r_cda_hi, r_cda_lo, r_cdb_hi, r_cdb_lo;

    assign area_p = $signed({{(TW-sit_pkg::AREA_TOL_W){1'b0}}, r_area_tol});
    assign area_n = -area_p;
    assign abc_t  = {{(TW-OW){abc[OW-1]}}, abc};
    assign abd_t  = {{(TW-OW){abd[OW-1]}}, abd};
    assign cda_t  = {{(TW-OW){cda[OW-1]}}, cda};
    assign cdb_t  = {{(TW-OW){cdb[OW-1]}}, cdb};

    always_ff @(posedge i_clk) begin
        r_abc_hi <= abc_t > area_p;
        r_abc_lo <= abc_t < area_n;
        r_abd_hi <= abd_t > area_p;
        r_abd_lo <= abd_t < area_n;
        r_cda_hi <= cda_t > area_p;
        r_cda_lo <= cda_t < area_n;
        r_cdb_hi <= cdb_t > area_p;
        r_cdb_lo <= cdb_t < area_n;
    end

    // Stage 5: no box reject, and proper straddle of both segments or an endpoint on the other.
    logic n_s1, n_s2, n_touch, r_intersects;

    assign n_s1    = (r_abc_hi && r_abd_lo) || (r_abc_lo && r_abd_hi);
    assign n_s2    = (r_cda_hi && r_cdb_lo) || (r_cda_lo && r_cdb_hi);
    assign n_touch = (!r_abc_hi && !r_abc_lo && r_box4.c_in_ab) ||
                     (!r_abd_hi && !r_abd_lo && r_box4.d_in_ab) ||
                     (!r_cda_hi && !r_cda_lo && r_box4.a_in_cd) ||
                     (!r_cdb_hi && !r_cdb_lo && r_box4.b_in_cd);

    always_ff @(posedge i_clk) begin
        r_intersects <= !r_box4.reject && ((n_s1 && n_s2) || n_touch);
    end

    assign o_done       = r_done;
    assign o_intersects = r_intersects;

`ifndef SYNTH
    // Every accepted word yields a strobe on o_done once it has passed through r_v1 to r_v4 and r_done.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_done)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 5))
        else $error("result strobe without an accepted word");

    // A pair rejected by the box check never reports an intersection.
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_box4.reject) |=> !o_intersects)
        else $error("box-rejected pair reported as intersecting");
`endif

endmodule
